// File: rtl/plbc_pkg.sv
// Package: shared types, constants and commands for the pinned LRU byte-budget cache.
`default_nettype none
package plbc_pkg;
    localparam int unsigned DefaultEntries = 64;
    localparam logic [31:0] BudgetReset    = 32'd33554432;
    localparam logic [15:0] PinMax         = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_FIND       = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_RELEASE    = 3'd3,
        CMD_INVALIDATE = 3'd4,
        CMD_FLUSH      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_PINNED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_ADDR,
        S_LOOK,
        S_ACT,
        S_EV_CHECK,
        S_EV_ADDR,
        S_EV_SCAN,
        S_EV_DROP,
        S_SWEEP_ADDR,
        S_SWEEP,
        S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture input word, clear result fields
        logic scan_start; // reset scan index and search flags
        logic scan_step;  // examine current entry, advance index
        logic act;        // apply the command to the located slot
        logic ev_start;   // reset victim search
        logic ev_step;    // examine current entry for the victim search
        logic ev_drop;    // drop the chosen victim
        logic sweep_step; // invalidate/flush one entry
    } cmd_bus_t;

    // Datapath to controller
    typedef struct packed {
        logic last;       // scan index is at the final entry
        logic over;       // held total exceeds budget
        logic have_victim;
        logic need_evict; // act decided an eviction pass is due
        logic sweep_cmd;  // command is invalidate or flush
        logic look_cmd;   // command needs a key lookup
    } stat_bus_t;
endpackage
`default_nettype wire

// File: rtl/plbc_ctrl.sv
// Controller: sequences lookup, command action, eviction and sweep passes.
`default_nettype none
module plbc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output plbc_pkg::cmd_bus_t        cmd_o,
    input  wire plbc_pkg::stat_bus_t  stat_i
);
    import plbc_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = S_LOOK_ADDR;
                end
            end
            S_LOOK_ADDR: begin
                cmd_o.scan_start = 1'b1;
                if (stat_i.sweep_cmd)     state_next = S_SWEEP;
                else if (stat_i.look_cmd) state_next = S_LOOK;
                else                      state_next = S_OUT;
            end
            S_LOOK: begin
                cmd_o.scan_step = 1'b1;
                if (stat_i.last) state_next = S_ACT;
            end
            S_ACT: begin
                cmd_o.act = 1'b1;
                state_next = stat_i.need_evict ? S_EV_CHECK : S_OUT;
            end
            S_EV_CHECK: begin
                state_next = stat_i.over ? S_EV_ADDR : S_OUT;
            end
            S_EV_ADDR: begin
                cmd_o.ev_start = 1'b1;
                state_next = S_EV_SCAN;
            end
            S_EV_SCAN: begin
                cmd_o.ev_step = 1'b1;
                if (stat_i.last) state_next = S_EV_DROP;
            end
            S_EV_DROP: begin
                if (stat_i.have_victim) begin
                    cmd_o.ev_drop = 1'b1;
                    state_next = S_EV_CHECK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SWEEP_ADDR: state_next = S_SWEEP;
            S_SWEEP: begin
                cmd_o.sweep_step = 1'b1;
                if (stat_i.last) state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid together");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.load |=> !s_ready) else $error("accepted twice");
`endif
endmodule
`default_nettype wire

// File: rtl/plbc_dpath.sv
// Datapath: entry table, byte total, use clock and per-command scan logic.
`default_nettype none
module plbc_dpath #(
    parameter int unsigned ENTRIES = plbc_pkg::DefaultEntries
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [31:0]          cfg_wdata,
    input  wire logic [2:0]           s_cmd,
    input  wire logic [63:0]          s_key,
    input  wire logic [24:0]          s_entry_bytes,
    output logic [1:0]                m_status,
    output logic                      m_hit,
    output logic [6:0]                m_pinned_count,
    output logic [6:0]                m_evicted_count,
    output logic [31:0]               m_total_bytes_now,
    input  wire plbc_pkg::cmd_bus_t   cmd_i,
    output plbc_pkg::stat_bus_t       stat_o
);
    import plbc_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

    // Entry table memories
    logic [63:0] key_mem   [ENTRIES];
    logic [24:0] size_mem  [ENTRIES];
    logic [15:0] pins_mem  [ENTRIES];
    logic [63:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic [31:0] budget_reg;
    logic [63:0] clock_reg;
    logic [31:0] held_reg;
    logic [2:0]  cmd_reg;
    logic [63:0] key_reg;
    logic [24:0] bytes_reg;
    logic [1:0]  status_reg;
    logic        hit_reg;
    logic [6:0]  pinned_reg;
    logic [6:0]  evict_reg;

    logic [IW-1:0] idx_reg;
    logic          found_reg, free_ok_reg;
    logic [IW-1:0] found_idx_reg, free_idx_reg;
    logic          vic_ok_reg;
    logic [IW-1:0] vic_idx_reg;
    logic [63:0]   vic_stamp_reg;

    // Victim size captured during the search
    logic [24:0] size_mem_vic_reg;

    // Registered reads at the scan index (or the chosen slot)
    logic [IW-1:0] raddr;
    logic [63:0]   rd_key_reg, rd_stamp_reg;
    logic [24:0]   rd_size_reg;
    logic [15:0]   rd_pins_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_valid;

    // Memory write port
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [63:0]   wr_key, wr_stamp;
    logic [24:0]   wr_size;
    logic [15:0]   wr_pins;

    logic [IW-1:0] idx_next;
    logic          scanning;
    logic          found_hit, free_hit;

    assign scanning = cmd_i.scan_step || cmd_i.ev_step || cmd_i.sweep_step;
    assign idx_next = scanning ? idx_reg + 1'b1 : '0;

    // Match and free slot seen on the entry examined this cycle
    assign found_hit = cmd_i.scan_step && !found_reg && rd_valid && rd_key_reg == key_reg;
    assign free_hit  = cmd_i.scan_step && !free_ok_reg && !rd_valid;

    // Address to read: the next scan index, or the located slot before act
    always_comb begin
        if (scanning || cmd_i.scan_start || cmd_i.ev_start) raddr = idx_next;
        else if (found_reg)                                  raddr = found_idx_reg;
        else                                                 raddr = free_idx_reg;
        if (scanning && idx_reg == LastIdx) begin
            if (found_reg)        raddr = found_idx_reg;
            else if (found_hit)   raddr = rd_idx_reg;
            else if (free_ok_reg) raddr = free_idx_reg;
            else                  raddr = rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key_reg   <= key_mem[raddr];
        rd_size_reg  <= size_mem[raddr];
        rd_pins_reg  <= pins_mem[raddr];
        rd_stamp_reg <= stamp_mem[raddr];
        rd_idx_reg   <= raddr;
        if (wr_en) begin
            key_mem[wr_idx]   <= wr_key;
            size_mem[wr_idx]  <= wr_size;
            pins_mem[wr_idx]  <= wr_pins;
            stamp_mem[wr_idx] <= wr_stamp;
        end
    end
    assign rd_valid = valid_reg[rd_idx_reg];

    // Saturating add and floored subtract
    function automatic logic [31:0] sat_add(logic [31:0] a, logic [24:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction
    function automatic logic [31:0] floor_sub(logic [31:0] a, logic [24:0] b);
        return (a >= 32'(b)) ? a - 32'(b) : '0;
    endfunction
    function automatic logic [6:0] inc7(logic [6:0] v);
        return (v == 7'h7F) ? v : v + 7'd1;
    endfunction

    // Act decisions
    logic [63:0] clock_inc;
    logic        act_wr;
    logic [15:0] act_pins;
    logic [31:0] act_held;
    logic        act_valid_set, act_valid_clr;
    logic [1:0]  act_status;
    logic        act_hit, act_need, act_clock;
    logic [IW-1:0] act_slot;
    assign clock_inc = clock_reg + 64'd1;
    assign act_slot  = found_reg ? found_idx_reg : free_idx_reg;

    always_comb begin
        act_wr = 1'b0; act_pins = rd_pins_reg; act_held = held_reg;
        act_valid_set = 1'b0; act_valid_clr = 1'b0;
        act_status = ST_OK; act_hit = 1'b0; act_need = 1'b0; act_clock = 1'b0;
        unique case (cmd_reg)
            CMD_FIND: begin
                if (!found_reg) act_status = ST_ABSENT;
                else begin
                    act_wr = 1'b1; act_clock = 1'b1; act_hit = 1'b1;
                    act_pins = (rd_pins_reg == PinMax) ? rd_pins_reg : rd_pins_reg + 16'd1;
                end
            end
            CMD_INSERT: begin
                if (!found_reg && !free_ok_reg) act_status = ST_FULL;
                else begin
                    act_wr = 1'b1; act_clock = 1'b1; act_pins = 16'd1;
                    act_valid_set = 1'b1; act_need = 1'b1;
                    act_held = sat_add(found_reg ? floor_sub(held_reg, rd_size_reg)
                                                 : held_reg, bytes_reg);
                end
            end
            CMD_REMOVE: begin
                if (!found_reg) act_status = ST_ABSENT;
                else begin
                    act_valid_clr = 1'b1;
                    act_held = floor_sub(held_reg, rd_size_reg);
                end
            end
            CMD_RELEASE: begin
                if (!found_reg) act_status = ST_ABSENT;
                else if (rd_pins_reg == 16'd0) act_status = ST_NOT_PINNED;
                else begin
                    act_wr = 1'b1; act_pins = rd_pins_reg - 16'd1;
                    act_need = (rd_pins_reg == 16'd1);
                end
            end
            default: ;
        endcase
    end

    // Write port select
    always_comb begin
        wr_en = cmd_i.act && act_wr;
        wr_idx = act_slot;
        wr_pins = act_pins;
        wr_stamp = act_clock ? clock_inc : rd_stamp_reg;
        wr_key = (cmd_reg == CMD_INSERT) ? key_reg : rd_key_reg;
        wr_size = (cmd_reg == CMD_INSERT) ? bytes_reg : rd_size_reg;
    end

    // Sweep decisions on the registered entry
    logic sw_drop, sw_pinned;
    always_comb begin
        sw_drop = rd_valid && rd_pins_reg == 16'd0 &&
                  (cmd_reg == CMD_FLUSH || rd_key_reg[63]);
        sw_pinned = rd_valid && rd_pins_reg != 16'd0 && cmd_reg == CMD_FLUSH;
    end

    // Control registers and table bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            budget_reg <= BudgetReset;
            clock_reg  <= '0;
            held_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            if (cfg_we) budget_reg <= cfg_wdata;
            idx_reg <= idx_next;
            if (cmd_i.act) begin
                held_reg <= act_held;
                if (act_clock) clock_reg <= clock_inc;
                if (act_valid_set) valid_reg[act_slot] <= 1'b1;
                if (act_valid_clr) valid_reg[act_slot] <= 1'b0;
            end
            if (cmd_i.ev_drop) begin
                valid_reg[vic_idx_reg] <= 1'b0;
                held_reg <= floor_sub(held_reg, size_mem_vic_reg);
            end
            if (cmd_i.sweep_step && sw_drop) begin
                valid_reg[rd_idx_reg] <= 1'b0;
                held_reg <= floor_sub(held_reg, rd_size_reg);
            end
        end
    end

    // Scan results and result fields
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            cmd_reg <= s_cmd; key_reg <= s_key; bytes_reg <= s_entry_bytes;
            status_reg <= ST_OK; hit_reg <= 1'b0; pinned_reg <= '0; evict_reg <= '0;
        end
        if (cmd_i.scan_start) begin
            found_reg <= 1'b0; free_ok_reg <= 1'b0;
            found_idx_reg <= '0; free_idx_reg <= '0;
        end
        if (found_hit) begin
            found_reg <= 1'b1; found_idx_reg <= rd_idx_reg;
        end
        if (free_hit) begin
            free_ok_reg <= 1'b1; free_idx_reg <= rd_idx_reg;
        end
        if (cmd_i.act) begin
            status_reg <= act_status; hit_reg <= act_hit;
            if (act_valid_clr) evict_reg <= 7'd1;
        end
        if (cmd_i.ev_start) vic_ok_reg <= 1'b0;
        if (cmd_i.ev_step && rd_valid && rd_pins_reg == 16'd0 &&
            (!vic_ok_reg || rd_stamp_reg < vic_stamp_reg)) begin
            vic_ok_reg <= 1'b1; vic_idx_reg <= rd_idx_reg;
            vic_stamp_reg <= rd_stamp_reg; size_mem_vic_reg <= rd_size_reg;
        end
        if (cmd_i.ev_drop) evict_reg <= inc7(evict_reg);
        if (cmd_i.sweep_step) begin
            if (sw_drop)   evict_reg  <= inc7(evict_reg);
            if (sw_pinned) pinned_reg <= inc7(pinned_reg);
        end
    end

    assign stat_o.last        = (idx_reg == LastIdx);
    assign stat_o.over        = (held_reg > budget_reg);
    assign stat_o.have_victim = vic_ok_reg;
    assign stat_o.need_evict  = act_need;
    assign stat_o.sweep_cmd   = (cmd_reg == CMD_INVALIDATE) || (cmd_reg == CMD_FLUSH);
    assign stat_o.look_cmd    = (cmd_reg == CMD_FIND) || (cmd_reg == CMD_INSERT) ||
                                (cmd_reg == CMD_REMOVE) || (cmd_reg == CMD_RELEASE);

    assign m_status          = status_reg;
    assign m_hit             = hit_reg;
    assign m_pinned_count    = pinned_reg;
    assign m_evicted_count   = evict_reg;
    assign m_total_bytes_now = held_reg;

`ifndef SYNTHESIS
    a_drop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.ev_drop |-> valid_reg[vic_idx_reg]) else $error("victim not valid");
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_hit |-> m_status == ST_OK) else $error("hit with error status");
    a_clock_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd_i.act |=> clock_reg == $past(clock_reg)) else $error("clock moved");
`endif
endmodule
`default_nettype wire

// File: rtl/pinned_lru_byte_budget_cache.sv
// Top level: pinned LRU cache with byte budget, controller plus datapath.
// Usage:
//   Input channel s_valid/s_ready carries one command word (s_cmd, s_key,
//   s_entry_bytes). Result channel m_valid/m_ready returns one word per command.
//   cfg_we/cfg_wdata write the byte budget; write only while the block is idle.
// Sequence: find, remove and release scan the table once, one entry per cycle.
//   An insert, or a release that unpins an entry, adds a budget check, then
//   each eviction is a further pass over the table to find the oldest unpinned
//   entry. Invalidate and flush sweep the table once. Unknown commands skip
//   the table and go straight to the result word. The single table read port
//   paces each scan.
// Throughput: one command at a time; the next word is taken after the result
//   word is accepted.
// Reset: aresetn (synchronous, active low) empties the table, clears the byte
//   total and use clock, and restores the budget to its default; no clearing
//   pass is needed.
// Stall: while m_ready is low the result word holds and s_ready stays low.
`default_nettype none
module pinned_lru_byte_budget_cache #(
    parameter int unsigned ENTRIES = plbc_pkg::DefaultEntries
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [63:0] s_key,
    input  wire logic [24:0] s_entry_bytes,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_hit,
    output logic [6:0]       m_pinned_count,
    output logic [6:0]       m_evicted_count,
    output logic [31:0]      m_total_bytes_now
);
    import plbc_pkg::*;

    cmd_bus_t  cmd_bus;
    stat_bus_t stat_bus;

    plbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd_o(cmd_bus), .stat_i(stat_bus)
    );

    plbc_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_cmd(s_cmd), .s_key(s_key), .s_entry_bytes(s_entry_bytes),
        .m_status(m_status), .m_hit(m_hit),
        .m_pinned_count(m_pinned_count), .m_evicted_count(m_evicted_count),
        .m_total_bytes_now(m_total_bytes_now),
        .cmd_i(cmd_bus), .stat_o(stat_bus)
    );
endmodule
`default_nettype wire

// File: test/pinned_lru_byte_budget_cache_chk.sv
// Checker for the pinned LRU byte-budget cache: predicts each result word and compares.
`timescale 1ns / 1ps
`default_nettype none
module pinned_lru_byte_budget_cache_chk #(
    parameter int unsigned ENTRIES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [63:0] s_key,
    input  wire logic [24:0] s_entry_bytes,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic        m_hit,
    input  wire logic [6:0]  m_pinned_count,
    input  wire logic [6:0]  m_evicted_count,
    input  wire logic [31:0] m_total_bytes_now,
    output int               fail_count,
    output int               pending
);
    import plbc_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [6:0]  pinned;
        logic [6:0]  evicted;
        logic [31:0] total;
    } answer_t;

    // Shadow copy of the cache table
    logic        sh_valid [ENTRIES];
    logic [63:0] sh_key   [ENTRIES];
    logic [24:0] sh_size  [ENTRIES];
    logic [15:0] sh_pins  [ENTRIES];
    logic [63:0] sh_stamp [ENTRIES];
    logic [63:0] sh_clock;
    logic [31:0] sh_held;
    logic [31:0] sh_budget;

    answer_t answers_due[$];

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (sh_valid[i] && sh_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void take_bytes(logic [24:0] n);
        sh_held = (sh_held >= {7'd0, n}) ? sh_held - {7'd0, n} : 32'd0;
    endfunction

    function automatic void drop_slot(int i);
        take_bytes(sh_size[i]);
        sh_valid[i] = 1'b0;
    endfunction

    // Drop oldest unpinned entries while over budget
    function automatic int trim_to_budget();
        int n;
        int best;
        n = 0;
        while (sh_held > sh_budget) begin
            best = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (sh_valid[i] && sh_pins[i] == 0 &&
                    (best < 0 || sh_stamp[i] < sh_stamp[best])) best = i;
            if (best < 0) break;
            drop_slot(best);
            n++;
        end
        return n;
    endfunction

    function automatic answer_t apply_command(logic [2:0] c, logic [63:0] k, logic [24:0] b);
        answer_t a;
        int slot;
        int pinned;
        int evicted;
        logic [32:0] sum;
        a = '0;
        pinned = 0;
        evicted = 0;
        case (c)
            CMD_FIND: begin
                slot = find_slot(k);
                if (slot < 0) a.status = ST_ABSENT;
                else begin
                    if (sh_pins[slot] != PinMax) sh_pins[slot]++;
                    sh_clock++;
                    sh_stamp[slot] = sh_clock;
                    a.hit = 1'b1;
                end
            end
            CMD_INSERT: begin
                slot = find_slot(k);
                if (slot >= 0) take_bytes(sh_size[slot]);
                else begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!sh_valid[i]) begin
                            slot = i;
                            break;
                        end
                end
                if (slot < 0) a.status = ST_FULL;
                else begin
                    sh_valid[slot] = 1'b1;
                    sh_key[slot] = k;
                    sh_size[slot] = b;
                    sh_pins[slot] = 16'd1;
                    sh_clock++;
                    sh_stamp[slot] = sh_clock;
                    sum = {1'b0, sh_held} + {8'd0, b};
                    sh_held = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    evicted = trim_to_budget();
                end
            end
            CMD_REMOVE: begin
                slot = find_slot(k);
                if (slot < 0) a.status = ST_ABSENT;
                else begin
                    drop_slot(slot);
                    evicted = 1;
                end
            end
            CMD_RELEASE: begin
                slot = find_slot(k);
                if (slot < 0) a.status = ST_ABSENT;
                else if (sh_pins[slot] == 0) a.status = ST_NOT_PINNED;
                else begin
                    sh_pins[slot]--;
                    if (sh_pins[slot] == 0) evicted = trim_to_budget();
                end
            end
            CMD_INVALIDATE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (sh_valid[i] && sh_key[i][63] && sh_pins[i] == 0) begin
                        drop_slot(i);
                        evicted++;
                    end
            end
            CMD_FLUSH: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (sh_valid[i]) begin
                        if (sh_pins[i] == 0) begin
                            drop_slot(i);
                            evicted++;
                        end else pinned++;
                    end
            end
            default: ;
        endcase
        a.pinned = (pinned > 127) ? 7'd127 : pinned[6:0];
        a.evicted = (evicted > 127) ? 7'd127 : evicted[6:0];
        a.total = sh_held;
        return a;
    endfunction

    assign pending = answers_due.size();

    // Track config, predict on accepted input, compare on accepted output
    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 1'b0;
            sh_clock  = '0;
            sh_held   = '0;
            sh_budget = BudgetReset;
            answers_due.delete();
        end else begin
            if (cfg_we) sh_budget = cfg_wdata;
            if (s_valid && s_ready)
                answers_due = {answers_due, apply_command(s_cmd, s_key, s_entry_bytes)};
            if (m_valid && m_ready) begin
                got = '{m_status, m_hit, m_pinned_count, m_evicted_count, m_total_bytes_now};
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result word %p", got);
                end else begin
                    want = answers_due.pop_front();
                    if (want != got) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule
`default_nettype wire

// File: test/pinned_lru_byte_budget_cache_tb.sv
// Testbench top: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module pinned_lru_byte_budget_cache_tb;
    import plbc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = '0;
    logic [63:0] s_key = '0;
    logic [24:0] s_entry_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_hit;
    logic [6:0]  m_pinned_count;
    logic [6:0]  m_evicted_count;
    logic [31:0] m_total_bytes_now;
    int          fail_count;
    int          pending;
    logic        hold_off = 1'b0;
    int          words_sent = 0;
    logic [63:0] key_pool [16];

    always #5 aclk = ~aclk;

    pinned_lru_byte_budget_cache dut (.*);

    pinned_lru_byte_budget_cache_chk chk (.*);

    // Send one word, holding it until taken
    task automatic send_word(logic [2:0] c, logic [63:0] k, logic [24:0] b);
        s_valid <= 1'b1;
        s_cmd <= c;
        s_key <= k;
        s_entry_bytes <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_config(logic [31:0] budget);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= budget;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [24:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 25'd0;
            1: return 25'd16777216;
            2: return 25'h1FF_FFFF;
            3: return 25'($urandom);
            default: return 25'($urandom_range(1, 4000));
        endcase
    endfunction

    // Receiver stall pattern, with one long hold-off
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 7) != 0) || words_sent > 900;
    end

    initial begin
        while (words_sent < 300) @(posedge aclk);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #200ms;
        $display("FAIL pinned_lru_byte_budget_cache");
        $finish;
    end

    initial begin
        logic [2:0] c;
        int burst;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0001;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every command, misses, pin paths, size extremes
        send_word(CMD_FIND, key_pool[0], 25'd0);
        send_word(CMD_RELEASE, key_pool[0], 25'd0);
        send_word(CMD_REMOVE, key_pool[0], 25'd0);
        send_word(CMD_INSERT, key_pool[0], 25'd16777216);
        send_word(CMD_INSERT, key_pool[1], 25'h1FF_FFFF);
        send_word(CMD_INSERT, key_pool[2], 25'd100);
        send_word(CMD_FIND, key_pool[2], 25'd0);
        send_word(CMD_RELEASE, key_pool[2], 25'd0);
        send_word(CMD_RELEASE, key_pool[2], 25'd0);
        send_word(CMD_RELEASE, key_pool[2], 25'd0);
        send_word(CMD_INSERT, key_pool[0], 25'd5);
        send_word(CMD_RELEASE, key_pool[1], 25'd0);
        send_word(CMD_INVALIDATE, '0, '0);
        send_word(3'd6, '1, '1);
        send_word(3'd7, '0, '0);
        send_word(CMD_FLUSH, '0, '0);
        drain_and_config(32'd0);
        send_word(CMD_INSERT, key_pool[3], 25'd10);
        send_word(CMD_RELEASE, key_pool[3], 25'd0);
        send_word(CMD_FLUSH, '0, '0);

        // Random phases over several budgets
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: drain_and_config(32'd5000);
                1: drain_and_config(32'hFFFF_FFFF);
                2: drain_and_config(32'd20000);
                3: drain_and_config(32'd0);
                4: drain_and_config(32'($urandom_range(1000, 100000)));
                default: drain_and_config(BudgetReset);
            endcase
            for (int n = 0; n < 200; n += burst) begin
                burst = $urandom_range(1, 20);
                for (int j = 0; j < burst; j++) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5: c = CMD_INSERT;
                        6, 7, 8, 9: c = CMD_FIND;
                        10, 11, 12, 13, 14: c = CMD_RELEASE;
                        15, 16: c = CMD_REMOVE;
                        17: c = CMD_INVALIDATE;
                        18: c = ($urandom_range(0, 3) == 0) ? CMD_FLUSH : CMD_INSERT;
                        default: c = 3'($urandom_range(6, 7));
                    endcase
                    if ($urandom_range(0, 9) == 0) send_word(c, {$urandom, $urandom}, pick_size());
                    else send_word(c, key_pool[$urandom_range(0, 15)] ^
                                   {1'($urandom_range(0, 1)), 57'd0,
                                    6'($urandom_range(0, 39))},
                                   pick_size());
                end
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge aclk);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) $display("PASS pinned_lru_byte_budget_cache");
        else $display("FAIL pinned_lru_byte_budget_cache");
        $finish;
    end
endmodule
`default_nettype wire
